@@ rtl/core/trs_pkg.sv @@
package trs_pkg;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_COR_INIT,
    S_COR_STEP,
    S_COR_SAVE,
    S_LOAD,
    S_MUL,
    S_DRAIN,
    S_PREAD,
    S_PWAIT,
    S_STORE,
    S_EMIT
  } state_e;

  // Operand setup for each matrix product of the chain
  typedef enum logic [2:0] {
    ST_ROT,  // Ry * Rx
    ST_RZ,   // Rz * (Ry Rx)
    ST_SC,   // (Rz Ry Rx) * S
    ST_TR,   // T * (R S)
    ST_PAR   // Pw * L, parent already read into A
  } stage_e;

  typedef struct packed {
    logic       capture;
    logic       cor_init;
    logic       cor_step;
    logic       cor_save;
    logic [1:0] cor_ang;
    logic [4:0] iter;
    logic       ld_en;
    stage_e     ld;
    logic       mul_en;
    logic [1:0] mr;
    logic [1:0] mj;
    logic [1:0] mk;
    logic       rd_en;
    logic       wr_en;
    logic [3:0] idx;
    logic       set_v;
    logic       clr;
    logic [1:0] orow;
  } cmd_t;

  typedef struct packed {
    logic parent_ok;
    logic slot_ok;
  } stat_t;

  localparam int CORDIC_ITERS = 30;
  localparam int MAT_WORDS    = 12;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // atan(2^-i), 2^32 = one turn
  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

endpackage

@@ rtl/core/trs_ctrl.sv @@
module trs_ctrl #(
  parameter int SLOTS = 256,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  trs_pkg::stat_t  stat_i,
  output trs_pkg::cmd_t   cmd_o,
  output logic [SW-1:0]   clr_addr_o
);

  trs_pkg::state_e state_q, state_d;
  trs_pkg::stage_e mst_q;
  logic [SW-1:0] clr_q;
  logic [1:0]    ang_q;
  logic [4:0]    iter_q;
  logic [1:0]    r_q, j_q, k_q;
  logic [3:0]    idx_q;
  logic [1:0]    row_q;

  logic mul_last, idx_last, post_store;

  assign mul_last   = (r_q == 2'd2) && (j_q == 2'd3) && (k_q == 2'd2);
  assign idx_last   = (idx_q == 4'(trs_pkg::MAT_WORDS - 1));
  assign post_store = stat_i.slot_ok;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trs_pkg::S_CLEAR:    if (clr_q == SW'(SLOTS - 1)) state_d = trs_pkg::S_IDLE;
      trs_pkg::S_IDLE:     if (in_valid_i) state_d = trs_pkg::S_COR_INIT;
      trs_pkg::S_COR_INIT: state_d = trs_pkg::S_COR_STEP;
      trs_pkg::S_COR_STEP: begin
        if (iter_q == 5'(trs_pkg::CORDIC_ITERS - 1)) state_d = trs_pkg::S_COR_SAVE;
      end
      trs_pkg::S_COR_SAVE: state_d = (ang_q == 2'd2) ? trs_pkg::S_LOAD : trs_pkg::S_COR_INIT;
      trs_pkg::S_LOAD:     state_d = trs_pkg::S_MUL;
      trs_pkg::S_MUL:      if (mul_last) state_d = trs_pkg::S_DRAIN;
      trs_pkg::S_DRAIN: begin
        priority if (mst_q == trs_pkg::ST_TR && stat_i.parent_ok) begin
          state_d = trs_pkg::S_PREAD;
        end else if (mst_q == trs_pkg::ST_TR || mst_q == trs_pkg::ST_PAR) begin
          state_d = post_store ? trs_pkg::S_STORE : trs_pkg::S_EMIT;
        end else begin
          state_d = trs_pkg::S_LOAD;
        end
      end
      trs_pkg::S_PREAD:    if (idx_last) state_d = trs_pkg::S_PWAIT;
      trs_pkg::S_PWAIT:    state_d = trs_pkg::S_LOAD;
      trs_pkg::S_STORE:    if (idx_last) state_d = trs_pkg::S_EMIT;
      trs_pkg::S_EMIT:     if (out_ready_i && row_q == 2'd2) state_d = trs_pkg::S_IDLE;
      default:             state_d = trs_pkg::S_CLEAR;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.cor_ang = ang_q;
    cmd_o.iter    = iter_q;
    cmd_o.ld      = mst_q;
    cmd_o.mr      = r_q;
    cmd_o.mj      = j_q;
    cmd_o.mk      = k_q;
    cmd_o.idx     = idx_q;
    cmd_o.orow    = row_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    unique case (state_q)
      trs_pkg::S_CLEAR:    cmd_o.clr = 1'b1;
      trs_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      trs_pkg::S_COR_INIT: cmd_o.cor_init = 1'b1;
      trs_pkg::S_COR_STEP: cmd_o.cor_step = 1'b1;
      trs_pkg::S_COR_SAVE: cmd_o.cor_save = 1'b1;
      trs_pkg::S_LOAD:     cmd_o.ld_en = 1'b1;
      trs_pkg::S_MUL:      cmd_o.mul_en = 1'b1;
      trs_pkg::S_DRAIN:    ;
      trs_pkg::S_PREAD:    cmd_o.rd_en = 1'b1;
      trs_pkg::S_PWAIT:    ;
      trs_pkg::S_STORE: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.set_v = idx_last;
      end
      trs_pkg::S_EMIT:     out_valid_o = 1'b1;
      default:             ;
    endcase
  end

  assign clr_addr_o = clr_q;

  // Sequence counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trs_pkg::S_CLEAR;
      mst_q   <= trs_pkg::ST_ROT;
      clr_q   <= '0;
      ang_q   <= '0;
      iter_q  <= '0;
      r_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      idx_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        trs_pkg::S_CLEAR:    clr_q <= clr_q + 1'b1;
        trs_pkg::S_IDLE: begin
          ang_q <= '0;
          mst_q <= trs_pkg::ST_ROT;
        end
        trs_pkg::S_COR_INIT: iter_q <= '0;
        trs_pkg::S_COR_STEP: iter_q <= iter_q + 1'b1;
        trs_pkg::S_COR_SAVE: ang_q <= ang_q + 1'b1;
        trs_pkg::S_LOAD: begin
          r_q <= '0;
          j_q <= '0;
          k_q <= '0;
        end
        trs_pkg::S_MUL: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            if (j_q == 2'd3) begin
              j_q <= '0;
              r_q <= r_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        trs_pkg::S_DRAIN: begin
          if (mst_q != trs_pkg::ST_PAR) mst_q <= trs_pkg::stage_e'(mst_q + 3'd1);
          idx_q <= '0;
          row_q <= '0;
        end
        trs_pkg::S_PREAD:    idx_q <= idx_q + 1'b1;
        trs_pkg::S_PWAIT:    ;
        trs_pkg::S_STORE:    idx_q <= idx_q + 1'b1;
        trs_pkg::S_EMIT:     if (out_ready_i) row_q <= row_q + 1'b1;
        default:             ;
      endcase
    end
  end

endmodule

@@ rtl/core/trs_datapath.sv @@
module trs_datapath #(
  parameter int SLOTS      = 256,
  parameter int ANGLE_BITS = 16,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  trs_pkg::cmd_t       cmd_i,
  input  logic [SW-1:0]       clr_addr_i,
  input  logic [7:0]          slot_i,
  input  logic                has_parent_i,
  input  logic [7:0]          parent_slot_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic [15:0]         angle_x_i,
  input  logic [15:0]         angle_y_i,
  input  logic [15:0]         angle_z_i,
  input  logic signed [31:0]  scale_x_i,
  input  logic signed [31:0]  scale_y_i,
  input  logic signed [31:0]  scale_z_i,
  output trs_pkg::stat_t      stat_o,
  output logic signed [31:0]  elem_0_o,
  output logic signed [31:0]  elem_1_o,
  output logic signed [31:0]  elem_2_o,
  output logic signed [31:0]  elem_3_o
);

  localparam int AW = $clog2(SLOTS * trs_pkg::MAT_WORDS);
  localparam int AB = (ANGLE_BITS > 16) ? 16 : ANGLE_BITS;
  localparam logic [15:0] AMASK = 16'hFFFF << (16 - AB);
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  // Captured item
  logic [SW-1:0] sidx_q, pidx_q;
  logic          hp_q, prng_q, srng_q, pv_q;
  logic signed [31:0] px_q, py_q, pz_q, scx_q, scy_q, scz_q;
  logic [15:0]   ang_q [3];

  // Sine and cosine per axis, Q2.16
  logic signed [17:0] sn_q [3];
  logic signed [17:0] cs_q [3];

  // Matrix operands and result, index row*4+col
  logic signed [31:0] a_q [trs_pkg::MAT_WORDS];
  logic signed [31:0] b_q [trs_pkg::MAT_WORDS];
  logic signed [31:0] c_q [trs_pkg::MAT_WORDS];
  logic signed [31:0] ma [trs_pkg::MAT_WORDS];
  logic signed [31:0] mb [trs_pkg::MAT_WORDS];

  // Slot storage
  logic signed [31:0] wmem [SLOTS * trs_pkg::MAT_WORDS];
  logic               vmem [SLOTS];
  logic signed [31:0] rd_q;
  logic               rv_q;
  logic [3:0]         ridx_q;
  logic [AW-1:0]      waddr, raddr;

  // Capture item and look up the parent valid bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sidx_q   <= SW'(slot_i);
      pidx_q   <= SW'(parent_slot_i);
      hp_q     <= has_parent_i;
      srng_q   <= ({24'd0, slot_i} < SLOTS);
      prng_q   <= ({24'd0, parent_slot_i} < SLOTS);
      pv_q     <= vmem[SW'(parent_slot_i)];
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
      scx_q    <= scale_x_i;
      scy_q    <= scale_y_i;
      scz_q    <= scale_z_i;
      ang_q[0] <= angle_x_i;
      ang_q[1] <= angle_y_i;
      ang_q[2] <= angle_z_i;
    end
  end

  assign stat_o.parent_ok = hp_q & prng_q & pv_q;
  assign stat_o.slot_ok   = srng_q;

  // Valid bits: cleared by a sweep after reset, set on store
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      vmem[clr_addr_i] <= 1'b0;
    end else if (cmd_i.set_v) begin
      vmem[sidx_q] <= 1'b1;
    end
  end

  // CORDIC, one rotation per cycle
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;
  logic [15:0]        am;
  logic signed [33:0] z0, dx, dy, at, xs, ys;
  logic signed [17:0] sq, cq;

  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd8192) >>> 14;
    if (t > 34'sd65536) return 18'sd65536;
    if (t < -34'sd65536) return -18'sd65536;
    return t[17:0];
  endfunction

  always_comb begin
    am = ang_q[cmd_i.cor_ang] & AMASK;
    z0 = 34'($signed({am, 16'h0000}));
    dx = y_q >>> cmd_i.iter;
    dy = x_q >>> cmd_i.iter;
    at = 34'(trs_pkg::ATAN_TAB[cmd_i.iter]);
    xs = flip_q ? -x_q : x_q;
    ys = flip_q ? -y_q : y_q;
    sq = to_q16(ys);
    cq = to_q16(xs);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cor_init) begin
      x_q <= trs_pkg::CORDIC_X0;
      y_q <= '0;
      // fold into a quarter turn either side of zero
      priority if (z0 > 34'sd1073741824) begin
        z_q    <= z0 - 34'sd2147483648;
        flip_q <= 1'b1;
      end else if (z0 < -34'sd1073741824) begin
        z_q    <= z0 + 34'sd2147483648;
        flip_q <= 1'b1;
      end else begin
        z_q    <= z0;
        flip_q <= 1'b0;
      end
    end else if (cmd_i.cor_step) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
    if (cmd_i.cor_save) begin
      sn_q[cmd_i.cor_ang] <= sq;
      cs_q[cmd_i.cor_ang] <= cq;
    end
  end

  // Operand setup for the next product
  always_comb begin
    for (int e = 0; e < trs_pkg::MAT_WORDS; e++) begin
      ma[e] = (e == 0 || e == 5 || e == 10) ? ONE : 32'sd0;
      mb[e] = ma[e];
    end
    unique case (cmd_i.ld)
      trs_pkg::ST_ROT: begin
        ma[0]  = 32'(cs_q[1]);
        ma[2]  = 32'(sn_q[1]);
        ma[8]  = -32'(sn_q[1]);
        ma[10] = 32'(cs_q[1]);
        mb[5]  = 32'(cs_q[0]);
        mb[6]  = -32'(sn_q[0]);
        mb[9]  = 32'(sn_q[0]);
        mb[10] = 32'(cs_q[0]);
      end
      trs_pkg::ST_RZ: begin
        ma[0] = 32'(cs_q[2]);
        ma[1] = -32'(sn_q[2]);
        ma[4] = 32'(sn_q[2]);
        ma[5] = 32'(cs_q[2]);
        mb    = c_q;
      end
      trs_pkg::ST_SC: begin
        ma     = c_q;
        mb[0]  = scx_q;
        mb[5]  = scy_q;
        mb[10] = scz_q;
      end
      trs_pkg::ST_TR: begin
        ma[3]  = px_q;
        ma[7]  = py_q;
        ma[11] = pz_q;
        mb     = c_q;
      end
      trs_pkg::ST_PAR: begin
        ma = a_q;
        mb = c_q;
      end
      default: ;
    endcase
  end

  // Shared multiplier, then round, accumulate and saturate
  logic signed [31:0] a_sel, b_sel;
  logic signed [63:0] prod, p_q;
  logic               t_v_q;
  logic [1:0]         t_r_q, t_j_q, t_k_q;
  logic signed [47:0] rnd;
  logic signed [49:0] base, acc_n, acc_q;
  logic signed [31:0] sat;

  assign a_sel = a_q[{cmd_i.mr, cmd_i.mk}];
  assign b_sel = b_q[{cmd_i.mk, cmd_i.mj}];
  assign prod  = a_sel * b_sel;

  always_comb begin
    rnd   = 48'((p_q + 64'sd32768) >>> 16);
    base  = (t_j_q == 2'd3) ? 50'(a_q[{t_r_q, 2'd3}]) : 50'sd0;
    acc_n = ((t_k_q == 2'd0) ? base : acc_q) + 50'(rnd);
    priority if (acc_n > 50'sd2147483647) sat = 32'sh7FFF_FFFF;
    else if (acc_n < -50'sd2147483648)    sat = 32'sh8000_0000;
    else                                  sat = acc_n[31:0];
  end

  always_ff @(posedge clk_i) begin
    p_q   <= prod;
    t_v_q <= cmd_i.mul_en;
    t_r_q <= cmd_i.mr;
    t_j_q <= cmd_i.mj;
    t_k_q <= cmd_i.mk;
    if (t_v_q) begin
      acc_q <= acc_n;
      if (t_k_q == 2'd2) c_q[{t_r_q, t_j_q}] <= sat;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_en) begin
      a_q <= ma;
      b_q <= mb;
    end else if (rv_q) begin
      a_q[ridx_q] <= rd_q;
    end
  end

  // Slot table: write on store, registered read of the parent
  assign waddr = AW'({sidx_q, 3'b000}) + AW'({sidx_q, 2'b00}) + AW'(cmd_i.idx);
  assign raddr = AW'({pidx_q, 3'b000}) + AW'({pidx_q, 2'b00}) + AW'(cmd_i.idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) wmem[waddr] <= c_q[cmd_i.idx];
    if (cmd_i.rd_en) rd_q <= wmem[raddr];
    rv_q   <= cmd_i.rd_en;
    ridx_q <= cmd_i.idx;
  end

  // Row output
  assign elem_0_o = c_q[{cmd_i.orow, 2'd0}];
  assign elem_1_o = c_q[{cmd_i.orow, 2'd1}];
  assign elem_2_o = c_q[{cmd_i.orow, 2'd2}];
  assign elem_3_o = c_q[{cmd_i.orow, 2'd3}];

endmodule

@@ rtl/core/trs_transform_compose.sv @@
// Transform composer: one input beat per object update, three output beats
// (world rows 0, 1, 2, last_row on row 2) per item.
// Input beat: slot, optional parent slot, position, binary angles, scale.
// The local matrix T*Rz*Ry*Rx*S is built, multiplied by the parent's stored
// world matrix when the parent slot is valid, stored in the slot table and
// emitted.
// Items are processed one at a time, so the next input beat is taken the
// cycle after the last row is taken; nothing is stored when the slot is out
// of range. Each item runs the CORDIC for three angles and the single shared
// multiplier for four or five 3x4 products, with 12 parent reads and one
// wait state before the fifth product, then 12 table writes.
// Reset: a clearing pass resets all SLOTS slot valid bits; in_ready_o stays
// low during it.
// Output stall: out_valid_o holds each row until out_ready_i; the block waits,
// and in_ready_o stays low until all three rows are taken.
module trs_transform_compose #(
  parameter int SLOTS      = 256,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         slot_i,
  input  logic               has_parent_i,
  input  logic [7:0]         parent_slot_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [15:0]        angle_x_i,
  input  logic [15:0]        angle_y_i,
  input  logic [15:0]        angle_z_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] elem_0_o,
  output logic signed [31:0] elem_1_o,
  output logic signed [31:0] elem_2_o,
  output logic signed [31:0] elem_3_o,
  output logic               last_row_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  trs_pkg::cmd_t  cmd;
  trs_pkg::stat_t stat;
  logic [SW-1:0]  clr_addr;

  trs_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .clr_addr_o  (clr_addr)
  );

  trs_datapath #(
    .SLOTS      (SLOTS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .clr_addr_i    (clr_addr),
    .slot_i        (slot_i),
    .has_parent_i  (has_parent_i),
    .parent_slot_i (parent_slot_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .angle_x_i     (angle_x_i),
    .angle_y_i     (angle_y_i),
    .angle_z_i     (angle_z_i),
    .scale_x_i     (scale_x_i),
    .scale_y_i     (scale_y_i),
    .scale_z_i     (scale_z_i),
    .stat_o        (stat),
    .elem_0_o      (elem_0_o),
    .elem_1_o      (elem_1_o),
    .elem_2_o      (elem_2_o),
    .elem_3_o      (elem_3_o)
  );

  assign row_index_o = cmd.orow;
  assign last_row_o  = (cmd.orow == 2'd2);

`ifndef ASSERT_OFF
  // no input beat is taken while rows are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("input taken while rows pending");

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("block not busy after input beat");

  // row index stays within the three emitted rows
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> (row_index_o != 2'd3))
    else $error("row index out of range");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [7:0]         slot;
    logic               has_parent;
    logic [7:0]         parent_slot;
    logic signed [31:0] pos [3];
    logic [15:0]        angle [3];
    logic signed [31:0] scale [3];
    bit                 drain_first;
  } update_t;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] elem [4];
    logic        last;
  } row_beat_t;

  typedef longint mat34_t [3][4];

  localparam int NUM_SLOTS  = 256;
  localparam int RAND_ITEMS = 380;
  localparam int IDLE_LIMIT = 6000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] slot_i;
  logic has_parent_i;
  logic [7:0] parent_slot_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic [15:0] angle_x_i, angle_y_i, angle_z_i;
  logic signed [31:0] scale_x_i, scale_y_i, scale_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [1:0] row_index_o;
  logic signed [31:0] elem_0_o, elem_1_o, elem_2_o, elem_3_o;
  logic last_row_o;

  trs_transform_compose u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .slot_i, .has_parent_i, .parent_slot_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .angle_x_i, .angle_y_i, .angle_z_i,
    .scale_x_i, .scale_y_i, .scale_z_i, .out_valid_o, .out_ready_i, .row_index_o,
    .elem_0_o, .elem_1_o, .elem_2_o, .elem_3_o, .last_row_o
  );

  update_t   pending_updates [$];
  row_beat_t expected_rows [$];
  update_t   cur_update;

  // Predictor state: stored world matrices and their valid bits
  mat34_t world_mem [NUM_SLOTS];
  bit     world_ok [NUM_SLOTS];

  int errors;
  int idle_cycles;
  int send_gap;
  int recv_gap;
  int phase_cnt;
  int sent_cnt;
  int total_items;
  bit calm;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Q2.30 -> Q16.16, round half up, clamp to +-1.0
  function automatic longint q30_to_q16(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  // Rotation CORDIC on a binary angle
  function automatic void cordic_sincos(input logic [15:0] ang, output longint s,
                                        output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({32'h0, ang, 16'h0});
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z >= 64'sh80000000) z -= 64'sh100000000;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1'b1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1'b1;
    end
    for (int i = 0; i < trs_pkg::CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(trs_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(trs_pkg::ATAN_TAB[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = q30_to_q16(y);
    c = q30_to_q16(x);
  endfunction

  function automatic mat34_t unit_mat();
    mat34_t m;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 4; k++)
        m[r][k] = (r == k) ? 65536 : 0;
    return m;
  endfunction

  // Affine product with per-term rounding and saturation
  function automatic mat34_t affine_mul(mat34_t a, mat34_t b);
    mat34_t m;
    longint acc;
    for (int r = 0; r < 3; r++)
      for (int j = 0; j < 4; j++) begin
        acc = (j == 3) ? a[r][3] : 0;
        for (int k = 0; k < 3; k++)
          acc += (a[r][k] * b[k][j] + 32768) >>> 16;
        if (acc > 64'sh7FFFFFFF) acc = 64'sh7FFFFFFF;
        if (acc < -64'sh80000000) acc = -64'sh80000000;
        m[r][j] = acc;
      end
    return m;
  endfunction

  // Compose the world matrix of one update and queue its three rows
  task automatic compose_world(update_t u);
    mat34_t rx, ry, rz, sc, tr, w;
    longint s [3];
    longint c [3];
    row_beat_t b;
    for (int i = 0; i < 3; i++) cordic_sincos(u.angle[i], s[i], c[i]);
    rx = unit_mat(); ry = unit_mat(); rz = unit_mat(); sc = unit_mat(); tr = unit_mat();
    rx[1][1] = c[0]; rx[1][2] = -s[0]; rx[2][1] = s[0]; rx[2][2] = c[0];
    ry[0][0] = c[1]; ry[0][2] = s[1]; ry[2][0] = -s[1]; ry[2][2] = c[1];
    rz[0][0] = c[2]; rz[0][1] = -s[2]; rz[1][0] = s[2]; rz[1][1] = c[2];
    for (int i = 0; i < 3; i++) begin
      sc[i][i] = longint'(u.scale[i]);
      tr[i][3] = longint'(u.pos[i]);
    end
    w = affine_mul(tr, affine_mul(affine_mul(rz, affine_mul(ry, rx)), sc));
    if (u.has_parent && u.parent_slot < NUM_SLOTS && world_ok[u.parent_slot])
      w = affine_mul(world_mem[u.parent_slot], w);
    if (u.slot < NUM_SLOTS) begin
      world_mem[u.slot] = w;
      world_ok[u.slot] = 1'b1;
    end
    for (int r = 0; r < 3; r++) begin
      b.row = r[1:0];
      for (int k = 0; k < 4; k++) b.elem[k] = w[r][k][31:0];
      b.last = (r == 2);
      expected_rows.push_back(b);
    end
  endtask

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] pick_q16(bit is_scale);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if (is_scale) return $urandom_range(0, 1) ? $urandom_range(16384, 262144)
                                               : -$urandom_range(16384, 262144);
      return $signed($urandom_range(0, 1048575)) - 524288;
    end
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 32'h00010000;
        default: return 32'h00000000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic update_t rand_update();
    update_t u;
    u.slot = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    u.has_parent = ($urandom_range(0, 99) < 70);
    u.parent_slot = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 15))
                                                 : 8'($urandom);
    for (int i = 0; i < 3; i++) begin
      u.pos[i] = pick_q16(1'b0);
      u.angle[i] = 16'($urandom);
      u.scale[i] = pick_q16(1'b1);
    end
    u.drain_first = ($urandom_range(0, 99) < 2);
    return u;
  endfunction

  function automatic update_t make_update(logic [7:0] slot, logic hp, logic [7:0] ps,
                                          logic [31:0] p, logic [15:0] a, logic [31:0] s);
    update_t u;
    u.slot = slot;
    u.has_parent = hp;
    u.parent_slot = ps;
    for (int i = 0; i < 3; i++) begin
      u.pos[i] = p;
      u.angle[i] = a;
      u.scale[i] = s;
    end
    u.drain_first = 1'b0;
    return u;
  endfunction

  // Driver: present one update per beat, hold until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (in_valid_i && !in_ready_o) begin
      // hold
    end else begin
      if (in_valid_i) begin
        compose_world(cur_update);
        sent_cnt++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_updates.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_updates[0].drain_first && expected_rows.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        cur_update = pending_updates.pop_front();
        slot_i <= cur_update.slot;
        has_parent_i <= cur_update.has_parent;
        parent_slot_i <= cur_update.parent_slot;
        pos_x_i <= cur_update.pos[0];
        pos_y_i <= cur_update.pos[1];
        pos_z_i <= cur_update.pos[2];
        angle_x_i <= cur_update.angle[0];
        angle_y_i <= cur_update.angle[1];
        angle_z_i <= cur_update.angle[2];
        scale_x_i <= cur_update.scale[0];
        scale_y_i <= cur_update.scale[1];
        scale_z_i <= cur_update.scale[2];
        in_valid_i <= 1'b1;
        send_gap <= pick_gap();
      end
    end
  end

  // Monitor: random back-pressure, compare each row beat, watch for hangs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
      idle_cycles <= 0;
      phase_cnt <= 0;
      calm <= 1'b0;
    end else begin
      row_beat_t exp_row;
      logic [31:0] got [4];
      phase_cnt <= phase_cnt + 1;
      if (phase_cnt % 700 == 699) calm <= ~calm;
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) recv_gap <= pick_gap();
      end
      if (out_valid_o && out_ready_i) begin
        got = '{elem_0_o, elem_1_o, elem_2_o, elem_3_o};
        if (expected_rows.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected row beat row=%0d", row_index_o);
        end else begin
          exp_row = expected_rows.pop_front();
          if (row_index_o !== exp_row.row || last_row_o !== exp_row.last ||
              got[0] !== exp_row.elem[0] || got[1] !== exp_row.elem[1] ||
              got[2] !== exp_row.elem[2] || got[3] !== exp_row.elem[3]) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: row exp %0d %h %h %h %h last %0d, got %0d %h %h %h %h last %0d",
                       exp_row.row, exp_row.elem[0], exp_row.elem[1], exp_row.elem[2],
                       exp_row.elem[3], exp_row.last, row_index_o, got[0], got[1],
                       got[2], got[3], last_row_o);
          end
        end
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    update_t u;
    errors = 0;
    sent_cnt = 0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    slot_i = '0; has_parent_i = 1'b0; parent_slot_i = '0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0;
    angle_x_i = '0; angle_y_i = '0; angle_z_i = '0;
    scale_x_i = '0; scale_y_i = '0; scale_z_i = '0;
    for (int i = 0; i < NUM_SLOTS; i++) world_ok[i] = 1'b0;

    // Directed: identity, quadrant angles, extremes, parent cases
    pending_updates.push_back(make_update(8'd0, 1'b0, 8'd0, 32'h0, 16'h0000, 32'h10000));
    pending_updates.push_back(make_update(8'd1, 1'b1, 8'd200, 32'h30000, 16'h4000,
                                          32'h10000));
    pending_updates.push_back(make_update(8'd2, 1'b1, 8'd1, 32'hFFFF0000, 16'h8000,
                                          32'h20000));
    pending_updates.push_back(make_update(8'd3, 1'b1, 8'd2, 32'h12345, 16'hC000,
                                          32'hFFFF0000));
    pending_updates.push_back(make_update(8'd4, 1'b0, 8'd3, 32'h7FFFFFFF, 16'hFFFF,
                                          32'h7FFFFFFF));
    pending_updates.push_back(make_update(8'd5, 1'b1, 8'd4, 32'h80000000, 16'h2000,
                                          32'h80000000));
    pending_updates.push_back(make_update(8'd255, 1'b0, 8'd0, 32'h0, 16'h6000, 32'h8000));
    pending_updates.push_back(make_update(8'd255, 1'b1, 8'd255, 32'h10000, 16'h1234,
                                          32'h10000));
    pending_updates.push_back(make_update(8'd6, 1'b1, 8'd255, 32'h7FFFFFFF, 16'hA000,
                                          32'h7FFFFFFF));
    pending_updates.push_back(make_update(8'd6, 1'b1, 8'd6, 32'h80000000, 16'h0001,
                                          32'h7FFFFFFF));
    pending_updates.push_back(make_update(8'd7, 1'b1, 8'd6, 32'h1, 16'h7FFF, 32'h1));
    pending_updates.push_back(make_update(8'd8, 1'b0, 8'd7, 32'hFFFFFFFF, 16'h8001,
                                          32'h0));
    pending_updates.push_back(make_update(8'd9, 1'b1, 8'd128, 32'h55555555, 16'h3FFF,
                                          32'hAAAAAAAA));
    for (int i = 0; i < RAND_ITEMS; i++) begin
      u = rand_update();
      if (i == 0) u.drain_first = 1'b1;
      pending_updates.push_back(u);
    end
    total_items = pending_updates.size();

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every update is taken and every row has come back
    while (sent_cnt < total_items || expected_rows.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
